// ===== rtl/b64e_pkg.sv =====
// Shared types, constants and the alphabet function for the base64 stream encoder.
package b64e_pkg;

    localparam int CHAR_W      = 7;
    localparam int SEXTET_W    = 6;
    localparam int MAX_CHARS   = 4;
    localparam int CMDQ_DEPTH  = 4;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

    // One decoded byte: up to four characters to send, count minus one, and the message end
    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [1:0]                       cnt_m1;
        logic                             msg_last;
    } b64e_cmd_t;

    // Push side of the command queue
    typedef struct packed {
        logic      valid;
        b64e_cmd_t cmd;
    } b64e_push_t;

    // Map one sextet to its character of the standard alphabet
    function automatic logic [CHAR_W-1:0] enc_char(input logic [SEXTET_W-1:0] s);
        logic [CHAR_W-1:0] v;
        v = {1'b0, s};
        if (s < 6'd26)
            return 7'h41 + v;
        else if (s < 6'd52)
            return 7'h61 + v - 7'd26;
        else if (s < 6'd62)
            return 7'h30 + v - 7'd52;
        else if (s == 6'd62)
            return 7'h2B;
        else
            return 7'h2F;
    endfunction

endpackage

// ===== rtl/base64_stream_encoder_unit.sv =====
// Top level of the base64 stream encoder.
// Encodes a byte stream into base64 characters (standard alphabet, '=' padding); last_byte
// marks the final byte of a message, and out_last marks its final character. The front end
// decodes a byte in the cycle it is offered and writes it into the command queue at the
// accepting edge, so a new byte is taken every cycle while the queue has room (byte_stall is
// high whenever the queue is full, even in a cycle where the sender frees an entry). The
// sender then drives one character per cycle while char_stall is low, one to four per byte,
// so the output port sets the sustained rate: four characters for every three bytes inside
// long messages and four characters per byte for one-byte messages, with CMDQ_DEPTH bytes
// of slack between the two sides. The first character of a byte passes through the command
// queue and then the output register before it reaches the output.
module base64_stream_encoder_unit
#(
    parameter int CMDQ_DEPTH = b64e_pkg::CMDQ_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         byte_valid,
    output logic                         byte_stall,
    input  logic [7:0]                   data_byte,
    input  logic                         last_byte,
    output logic                         char_valid,
    input  logic                         char_stall,
    output logic [b64e_pkg::CHAR_W-1:0]  out_char,
    output logic                         out_last
);

    b64e_pkg::b64e_push_t push;
    b64e_pkg::b64e_cmd_t  head;
    logic                 queue_full;
    logic                 queue_empty;
    logic                 pop;

    b64e_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .queue_full (queue_full),
        .byte_stall (byte_stall),
        .push       (push)
    );

    b64e_queue #(.DEPTH(CMDQ_DEPTH)) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (queue_full),
        .empty (queue_empty),
        .head  (head)
    );

    b64e_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (queue_empty),
        .head       (head),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .out_char   (out_char),
        .out_last   (out_last)
    );

endmodule

// ===== rtl/b64e_front.sv =====
// Front end: accepts bytes, tracks the group phase and builds character commands.
module b64e_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    input  logic                  queue_full,
    output logic                  byte_stall,
    output b64e_pkg::b64e_push_t  push
);

    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] left_reg;
    logic [3:0] left_next;
    logic       accept;
    b64e_pkg::b64e_cmd_t cmd;

    assign byte_stall = queue_full;
    assign accept     = byte_valid && !queue_full;

    // Split the byte into sextets according to the phase
    always_comb
    begin
        cmd          = '0;
        cmd.msg_last = last_byte;
        phase_next   = PH_0;
        left_next    = 4'd0;
        unique case (phase_reg)
            PH_1:
            begin
                cmd.chars[0] = b64e_pkg::enc_char({left_reg[1:0], data_byte[7:4]});
                if (last_byte)
                begin
                    cmd.chars[1] = b64e_pkg::enc_char({data_byte[3:0], 2'b00});
                    cmd.chars[2] = b64e_pkg::PAD_CHAR;
                    cmd.cnt_m1   = 2'd2;
                end
                else
                begin
                    cmd.cnt_m1 = 2'd0;
                    left_next  = data_byte[3:0];
                    phase_next = PH_2;
                end
            end
            PH_2:
            begin
                cmd.chars[0] = b64e_pkg::enc_char({left_reg, data_byte[7:6]});
                cmd.chars[1] = b64e_pkg::enc_char(data_byte[5:0]);
                cmd.cnt_m1   = 2'd1;
            end
            default:
            begin
                cmd.chars[0] = b64e_pkg::enc_char(data_byte[7:2]);
                if (last_byte)
                begin
                    cmd.chars[1] = b64e_pkg::enc_char({data_byte[1:0], 4'b0000});
                    cmd.chars[2] = b64e_pkg::PAD_CHAR;
                    cmd.chars[3] = b64e_pkg::PAD_CHAR;
                    cmd.cnt_m1   = 2'd3;
                end
                else
                begin
                    cmd.cnt_m1 = 2'd0;
                    left_next  = {2'b00, data_byte[1:0]};
                    phase_next = PH_1;
                end
            end
        endcase
    end

    assign push.valid = accept;
    assign push.cmd   = cmd;

    // Advance the phase on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_0;
            left_reg  <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

// ===== rtl/b64e_queue.sv =====
// Short command queue between the front end and the character sender.
module b64e_queue
#(
    parameter int DEPTH = b64e_pkg::CMDQ_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  b64e_pkg::b64e_push_t  push,
    input  logic                  pop,
    output logic                  full,
    output logic                  empty,
    output b64e_pkg::b64e_cmd_t   head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b64e_pkg::b64e_cmd_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.cmd;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/b64e_back.sv =====
// Back end: sends the characters of each command through an output register, one per cycle while not stalled.
module b64e_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 empty,
    input  b64e_pkg::b64e_cmd_t                  head,
    output logic                                 pop,
    output logic                                 char_valid,
    input  logic                                 char_stall,
    output logic [b64e_pkg::CHAR_W-1:0]          out_char,
    output logic                                 out_last
);

    logic [1:0]                     idx_reg;
    logic                           valid_reg;
    logic [b64e_pkg::CHAR_W-1:0]    char_reg;
    logic                           last_reg;
    logic                           load;
    logic                           at_end;

    assign load   = (!valid_reg || !char_stall) && !empty;
    assign at_end = (idx_reg == head.cnt_m1);
    assign pop    = load && at_end;

    assign char_valid = valid_reg;
    assign out_char   = char_reg;
    assign out_last   = last_reg;

    // Step through the head command and drop it after its final character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= at_end ? 2'd0 : idx_reg + 2'd1;
            end
            else if (!char_stall)
                valid_reg <= 1'b0;
        end
    end

    // Hold the output word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= head.chars[idx_reg];
            last_reg <= head.msg_last && at_end;
        end
    end

endmodule

// ===== rtl/b64e_checker.sv =====
// Port-level checker for the base64 stream encoder, bound to the top level.
module b64e_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         char_valid,
    input logic                         char_stall,
    input logic [b64e_pkg::CHAR_W-1:0]  out_char,
    input logic                         out_last
);

    // Hold a stalled output word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_stall) |=> (char_valid && $stable(out_char) && $stable(out_last)))
        else $error("stalled output word changed");

    // Send only alphabet characters or padding
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> ((out_char >= 7'h41 && out_char <= 7'h5A)
                     || (out_char >= 7'h61 && out_char <= 7'h7A)
                     || (out_char >= 7'h30 && out_char <= 7'h39)
                     || out_char == 7'h2B || out_char == 7'h2F
                     || out_char == b64e_pkg::PAD_CHAR))
        else $error("character outside the base64 alphabet");

    // A first pad is followed at once by the final pad
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && !char_stall && out_char == b64e_pkg::PAD_CHAR && !out_last)
        |=> (char_valid && out_char == b64e_pkg::PAD_CHAR && out_last))
        else $error("pad pair broken");

endmodule

bind base64_stream_encoder_unit b64e_checker u_b64e_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .out_char   (out_char),
    .out_last   (out_last)
);

// ===== sim/tb.sv =====
// Testbench for the base64 stream encoder: random bytes in, characters checked against a predictor.
`timescale 1ns / 100ps

// Encoded character that the block must produce next
typedef struct {
    logic [b64e_pkg::CHAR_W-1:0] ch;
    logic                        fin;
} b64_char_t;

// Position within the current 3-byte group
typedef enum logic [1:0] {
    GRP_FIRST  = 2'd0,
    GRP_SECOND = 2'd1,
    GRP_THIRD  = 2'd2
} grp_pos_t;

class b64_char_scoreboard;
    string      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    grp_pos_t   grp_pos;
    logic [3:0] carry_bits;
    b64_char_t  pending_chars[$];
    int         mismatch_count;

    function new();
        grp_pos        = GRP_FIRST;
        carry_bits     = '0;
        mismatch_count = 0;
    endfunction

    function logic [b64e_pkg::CHAR_W-1:0] sextet_char(logic [5:0] s);
        logic [7:0] c;
        c = alphabet[int'(s)];
        return c[b64e_pkg::CHAR_W-1:0];
    endfunction

    function void push_char(logic [b64e_pkg::CHAR_W-1:0] ch, logic fin);
        b64_char_t e;
        e.ch  = ch;
        e.fin = fin;
        pending_chars.push_back(e);
    endfunction

    // Note an accepted byte: queue the characters it releases and advance the group
    function void take_byte(logic [7:0] b, logic fin);
        case (grp_pos)
            GRP_SECOND:
            begin
                push_char(sextet_char({carry_bits[1:0], b[7:4]}), 1'b0);
                if (fin)
                begin
                    push_char(sextet_char({b[3:0], 2'b00}), 1'b0);
                    push_char(b64e_pkg::PAD_CHAR, 1'b1);
                    grp_pos    = GRP_FIRST;
                    carry_bits = '0;
                end
                else
                begin
                    carry_bits = b[3:0];
                    grp_pos    = GRP_THIRD;
                end
            end
            GRP_THIRD:
            begin
                push_char(sextet_char({carry_bits, b[7:6]}), 1'b0);
                push_char(sextet_char(b[5:0]), fin);
                grp_pos    = GRP_FIRST;
                carry_bits = '0;
            end
            default:
            begin
                push_char(sextet_char(b[7:2]), 1'b0);
                if (fin)
                begin
                    push_char(sextet_char({b[1:0], 4'b0000}), 1'b0);
                    push_char(b64e_pkg::PAD_CHAR, 1'b0);
                    push_char(b64e_pkg::PAD_CHAR, 1'b1);
                    grp_pos    = GRP_FIRST;
                    carry_bits = '0;
                end
                else
                begin
                    carry_bits = {2'b00, b[1:0]};
                    grp_pos    = GRP_SECOND;
                end
            end
        endcase
    endfunction

    task report(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Compare one accepted character with the oldest expectation
    task match_char(logic [b64e_pkg::CHAR_W-1:0] ch, logic fin);
        b64_char_t e;
        if (pending_chars.size() == 0)
        begin
            report($sformatf("unexpected char 0x%02h last=%0b", ch, fin));
            return;
        end
        e = pending_chars.pop_front();
        if (ch !== e.ch)
            report($sformatf("out_char 0x%02h, want 0x%02h", ch, e.ch));
        if (fin !== e.fin)
            report($sformatf("out_last %0b, want %0b (char 0x%02h)", fin, e.fin, e.ch));
    endtask
endclass

module tb;

    logic                        clk        = 1'b0;
    logic                        rst_n      = 1'b0;
    logic                        byte_valid = 1'b0;
    logic                        byte_stall;
    logic [7:0]                  data_byte  = '0;
    logic                        last_byte  = 1'b0;
    logic                        char_valid;
    logic                        char_stall = 1'b0;
    logic [b64e_pkg::CHAR_W-1:0] out_char;
    logic                        out_last;

    // Suppress random idling on both sides while set
    logic              steady     = 1'b0;

    b64_char_scoreboard sb = new();

    base64_stream_encoder_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .out_char   (out_char),
        .out_last   (out_last)
    );

    always #4 clk = ~clk;

    // Offer one word, idling first at random, and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!steady && $urandom_range(0, 99) < 26)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= b;
        last_byte  <= fin;
        do
            @(posedge clk);
        while (byte_stall);
        sb.take_byte(b, fin);
    endtask

    // Send a short message given left-aligned in a 48-bit vector
    task automatic send_msg(input int n, input logic [47:0] v);
        for (int i = 0; i < n; i++)
            send_byte(v[47 - 8*i -: 8], i == n - 1);
    endtask

    // Take characters, check each, and stall at random
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (char_valid && !char_stall)
                sb.match_char(out_char, out_last);
            char_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 26);
        end
    end

    // Stimulus and end of run
    initial
    begin
        int sent;
        int len;
        sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every message tail length, field extremes, '+' and '/'
        send_msg(1, 48'h00_0000000000);
        send_msg(1, 48'hFF_0000000000);
        send_msg(2, 48'h00FF_00000000);
        send_msg(2, 48'hFF00_00000000);
        send_msg(3, 48'hFBEFBE_000000);
        send_msg(3, 48'hFFFFFF_000000);
        send_msg(4, 48'h55AA55AA_0000);
        send_msg(5, 48'h0102040810_00);

        // Random messages, mostly short, now and then a long one
        while (sent < 420)
        begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                steady = (sent >= 150 && sent < 260);
                send_byte(8'($urandom_range(0, 255)), i == len - 1);
                sent++;
            end
        end
        steady = 1'b0;
        byte_valid <= 1'b0;

        // Drain, then watch for stray characters
        while (sb.pending_chars.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.pending_chars.size() != 0)
            sb.report($sformatf("%0d chars never arrived", sb.pending_chars.size()));

        if (sb.mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder_unit.sv
rtl/b64e_checker.sv
sim/tb.sv
